/* rtl/sdlp_pkg.sv */
// ---------------------------------------------------------------------------
// Signed decimal list parser package
// Shared types and constants of the parser core.
// ---------------------------------------------------------------------------
package sdlp_pkg;

   localparam int unsigned RSP_FIFO_DEPTH = 4;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_MINUS  = 2'd1;
   localparam logic [1:0] PH_NUMBER = 2'd2;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;

   localparam logic [30:0] MAG_MAX = 31'h7FFF_FFFF;

   typedef struct packed {
      logic signed [31:0] number_value;
      logic               saturated;
      logic               run_last;
   } result_type;

   typedef struct packed {
      logic       valid0;
      logic       valid1;
      result_type res0;
      result_type res1;
   } push_type;

endpackage

/* rtl/signed_decimal_list_parser_core.sv */
// ---------------------------------------------------------------------------
// Signed decimal list parser core
// Reads text one character per transaction and returns the signed decimal
// integers found in it, saturated to 31 bits of magnitude.
//
//   Channel   Direction   Payload
//   req_      in          char_byte[7:0], end_of_string
//   rsp_      out         number_value[31:0] signed, saturated, run_last
//
// One character is taken per cycle while there is room; a minus that closes
// a number and ends the string yields two results, which leave one per cycle.
// The character register feeds the parser step, which writes the results
// into a small queue; the queue must have room for two results to advance.
// Reset is synchronous and returns the parser to idle with the queue empty.
// A stalled result side holds input back only once the queue is nearly full.
// ---------------------------------------------------------------------------
module signed_decimal_list_parser_core #(
   parameter int unsigned RspFifoDepth = sdlp_pkg::RSP_FIFO_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_char_byte,
   input  logic               req_end_of_string,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_number_value,
   output logic               rsp_saturated,
   output logic               rsp_run_last
);

   logic                 stg_valid_ff, stg_valid_in;
   logic [7:0]           stg_char_ff;
   logic                 stg_eos_ff;
   logic                 room;
   logic                 fire;
   sdlp_pkg::push_type   push;
   sdlp_pkg::result_type rsp_data;

   assign fire         = stg_valid_ff && room;
   assign req_ready    = !stg_valid_ff || room;
   assign stg_valid_in = (req_valid && req_ready) || (stg_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= stg_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         stg_char_ff <= req_char_byte;
         stg_eos_ff  <= req_end_of_string;
      end
   end

   sdlp_step u_step (
      .clock         (clock),
      .reset         (reset),
      .fire          (fire),
      .char_byte     (stg_char_ff),
      .end_of_string (stg_eos_ff),
      .push          (push)
   );

   sdlp_rsp_fifo #(
      .Depth (RspFifoDepth)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_number_value = rsp_data.number_value;
   assign rsp_saturated    = rsp_data.saturated;
   assign rsp_run_last     = rsp_data.run_last;

endmodule

/* rtl/sdlp_step.sv */
// ---------------------------------------------------------------------------
// Signed decimal list parser step
// Parse state and the per-character update, giving up to two results.
// ---------------------------------------------------------------------------
module sdlp_step (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         char_byte,
   input  logic               end_of_string,
   output sdlp_pkg::push_type push
);

   logic [1:0]  phase_ff, phase_in;
   logic [30:0] acc_ff, acc_in;
   logic        neg_ff, neg_in;
   logic        clamp_ff, clamp_in;

   logic        digit;
   logic [3:0]  dig;
   logic [34:0] sum;
   logic        ovf;

   logic [1:0]  mid_phase;
   logic [30:0] mid_acc;
   logic        mid_neg;
   logic        mid_clamp;
   logic        first_v, second_v;
   sdlp_pkg::result_type first_r, second_r;

   function automatic sdlp_pkg::result_type make_result(
      input logic [1:0]  phase,
      input logic [30:0] acc,
      input logic        neg,
      input logic        clamp
   );
      sdlp_pkg::result_type r;
      logic [31:0]          mag;
      mag = {1'b0, acc};
      r.run_last = 1'b0;
      if (phase == sdlp_pkg::PH_MINUS) begin
         r.number_value = '0;
         r.saturated    = 1'b0;
      end else begin
         r.number_value = neg ? (32'd0 - mag) : mag;
         r.saturated    = clamp;
      end
      return r;
   endfunction

   assign digit = (char_byte >= sdlp_pkg::CHAR_ZERO) && (char_byte <= sdlp_pkg::CHAR_NINE);
   assign dig   = 4'(char_byte - sdlp_pkg::CHAR_ZERO);
   assign sum   = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + {31'd0, dig};
   assign ovf   = clamp_ff || (sum > {4'd0, sdlp_pkg::MAG_MAX});

   always_comb begin
      first_v   = 1'b0;
      first_r   = make_result(phase_ff, acc_ff, neg_ff, clamp_ff);
      mid_phase = phase_ff;
      mid_acc   = acc_ff;
      mid_neg   = neg_ff;
      mid_clamp = clamp_ff;
      if (phase_ff == sdlp_pkg::PH_MINUS && digit) begin
         mid_phase = sdlp_pkg::PH_NUMBER;
         mid_acc   = {27'd0, dig};
         mid_clamp = 1'b0;
      end else if (phase_ff == sdlp_pkg::PH_NUMBER && digit) begin
         mid_acc   = ovf ? sdlp_pkg::MAG_MAX : sum[30:0];
         mid_clamp = ovf;
      end else begin
         first_v = (phase_ff == sdlp_pkg::PH_MINUS) || (phase_ff == sdlp_pkg::PH_NUMBER);
         mid_acc   = '0;
         mid_clamp = 1'b0;
         if (digit) begin
            mid_phase = sdlp_pkg::PH_NUMBER;
            mid_neg   = 1'b0;
            mid_acc   = {27'd0, dig};
         end else if (char_byte == sdlp_pkg::CHAR_MINUS) begin
            mid_phase = sdlp_pkg::PH_MINUS;
            mid_neg   = 1'b1;
         end else begin
            mid_phase = sdlp_pkg::PH_IDLE;
            mid_neg   = 1'b0;
         end
      end

      second_v = end_of_string &&
                 ((mid_phase == sdlp_pkg::PH_MINUS) || (mid_phase == sdlp_pkg::PH_NUMBER));
      second_r = make_result(mid_phase, mid_acc, mid_neg, mid_clamp);

      if (end_of_string) begin
         phase_in = sdlp_pkg::PH_IDLE;
         acc_in   = '0;
         neg_in   = 1'b0;
         clamp_in = 1'b0;
      end else begin
         phase_in = mid_phase;
         acc_in   = mid_acc;
         neg_in   = mid_neg;
         clamp_in = mid_clamp;
      end

      if (first_v) begin
         push.valid0 = fire;
         push.valid1 = fire && second_v;
         push.res0   = first_r;
         push.res1   = second_r;
      end else begin
         push.valid0 = fire && second_v;
         push.valid1 = 1'b0;
         push.res0   = second_r;
         push.res1   = second_r;
      end
      push.res0.run_last = !(first_v && second_v);
      push.res1.run_last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sdlp_pkg::PH_IDLE;
         acc_ff   <= '0;
         neg_ff   <= 1'b0;
         clamp_ff <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         neg_ff   <= neg_in;
         clamp_ff <= clamp_in;
      end
   end

endmodule

/* rtl/sdlp_rsp_fifo.sv */
// ---------------------------------------------------------------------------
// Signed decimal list parser result queue
// Small register queue that takes up to two results a cycle and gives one.
// Depth must be a power of two, at least two.
// ---------------------------------------------------------------------------
module sdlp_rsp_fifo #(
   parameter int unsigned Depth = sdlp_pkg::RSP_FIFO_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  sdlp_pkg::push_type   push,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output sdlp_pkg::result_type rsp_data
);

   localparam int unsigned PtrW   = $clog2(Depth);
   localparam int unsigned CountW = $clog2(Depth + 1);

   sdlp_pkg::result_type mem_ff [Depth];
   logic [PtrW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [PtrW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]      wr_ptr_next;
   logic [CountW-1:0]    count_ff, count_in;
   logic                 pop;

   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = mem_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign room        = (count_ff <= CountW'(Depth - 2));
   assign wr_ptr_next = wr_ptr_ff + PtrW'(1);

   always_comb begin
      rd_ptr_in = pop ? rd_ptr_ff + PtrW'(1) : rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff + PtrW'(push.valid0) + PtrW'(push.valid1);
      count_in  = count_ff + CountW'(push.valid0) + CountW'(push.valid1) - CountW'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.valid0) begin
         mem_ff[wr_ptr_ff] <= push.res0;
      end
      if (push.valid1) begin
         mem_ff[wr_ptr_next] <= push.res1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

/* tb/sv/tb_signed_decimal_list_parser_core.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Signed decimal list parser core testbench
// Feeds text one character per transaction and checks every returned number
// against a cycle-free model of the parser. A short table of directed
// characters comes first, then random lists of numbers with noise, while
// both handshake sides idle at random and the result side stalls for a long
// stretch once so that the core backs up onto its input.
// ---------------------------------------------------------------------------
module tb_signed_decimal_list_parser_core;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned RANDOM_ITEMS = 1450;
   localparam int unsigned HOLD_CYCLES = 300;

   typedef struct {
      logic [7:0]         char_code;
      logic               eos;
      bit                 pinned;
      logic signed [31:0] pinned_value;
      logic               pinned_sat;
   } char_row_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [7:0]         req_char_byte = 8'h00;
   logic               req_end_of_string = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_number_value;
   logic               rsp_saturated;
   logic               rsp_run_last;

   logic [1:0]  model_phase = sdlp_pkg::PH_IDLE;
   logic [30:0] model_magnitude = '0;
   logic        model_negative = 1'b0;
   logic        model_clamped = 1'b0;

   sdlp_pkg::result_type char_numbers[$];
   sdlp_pkg::result_type expected_numbers[$];
   char_row_type         directed_chars[$];
   logic [7:0]           text_buf[$];

   bit          req_no_idle = 1'b0;
   bit          rsp_no_idle = 1'b0;
   bit          stress_started = 1'b0;
   logic        hold_rsp = 1'b0;
   int unsigned rsp_wait = 0;
   int unsigned cycle_count = 0;
   int unsigned error_count = 0;
   int unsigned items_sent = 0;
   int unsigned results_seen = 0;
   int unsigned clamped_seen = 0;
   int unsigned negative_seen = 0;

   signed_decimal_list_parser_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_char_byte     (req_char_byte),
      .req_end_of_string (req_end_of_string),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_number_value  (rsp_number_value),
      .rsp_saturated     (rsp_saturated),
      .rsp_run_last      (rsp_run_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_numbers.size());
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   task automatic report_mismatch(input string msg);
      error_count++;
      $display("ERROR cycle %0d: %s", cycle_count, msg);
   endtask

   function automatic int unsigned pick_gap(inout bit no_idle);
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      return no_idle ? 0 : $urandom_range(0, 17);
   endfunction

   task automatic add_model_digit(input logic [3:0] digit);
      logic [34:0] next_mag;
      next_mag = {4'b0, model_magnitude} * 35'd10 + {31'b0, digit};
      if (model_clamped || next_mag > {4'b0, sdlp_pkg::MAG_MAX}) begin
         model_magnitude = sdlp_pkg::MAG_MAX;
         model_clamped = 1'b1;
      end else begin
         model_magnitude = next_mag[30:0];
      end
   endtask

   task automatic close_model_number();
      sdlp_pkg::result_type r;
      r.number_value = '0;
      r.saturated = 1'b0;
      r.run_last = 1'b0;
      if (model_phase == sdlp_pkg::PH_NUMBER) begin
         r.number_value = {1'b0, model_magnitude};
         if (model_negative) r.number_value = -r.number_value;
         r.saturated = model_clamped;
      end
      if (model_phase == sdlp_pkg::PH_MINUS || model_phase == sdlp_pkg::PH_NUMBER)
         char_numbers.insert(char_numbers.size(), r);
      model_phase = sdlp_pkg::PH_IDLE;
      model_magnitude = '0;
      model_negative = 1'b0;
      model_clamped = 1'b0;
   endtask

   task automatic parse_next_char(input logic [7:0] c, input logic eos);
      bit                   is_digit;
      sdlp_pkg::result_type r;
      char_numbers.delete();
      is_digit = (c >= sdlp_pkg::CHAR_ZERO) && (c <= sdlp_pkg::CHAR_NINE);
      if (model_phase == sdlp_pkg::PH_MINUS && is_digit) begin
         model_phase = sdlp_pkg::PH_NUMBER;
         model_magnitude = '0;
         model_clamped = 1'b0;
         add_model_digit(c[3:0]);
      end else if (model_phase == sdlp_pkg::PH_NUMBER && is_digit) begin
         add_model_digit(c[3:0]);
      end else begin
         close_model_number();
         if (is_digit) begin
            model_phase = sdlp_pkg::PH_NUMBER;
            model_negative = 1'b0;
            add_model_digit(c[3:0]);
         end else if (c == sdlp_pkg::CHAR_MINUS) begin
            model_phase = sdlp_pkg::PH_MINUS;
            model_negative = 1'b1;
         end
      end
      if (eos) close_model_number();
      for (int i = 0; i < char_numbers.size(); i++) begin
         r = char_numbers[i];
         r.run_last = (i == char_numbers.size() - 1);
         char_numbers[i] = r;
      end
   endtask

   task automatic drive_and_predict(input logic [7:0] c, input logic eos, input bit pinned,
                                    input logic signed [31:0] pinned_value,
                                    input logic pinned_sat);
      int unsigned          gap;
      sdlp_pkg::result_type r;
      gap = pick_gap(req_no_idle);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_char_byte <= c;
      req_end_of_string <= eos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
      parse_next_char(c, eos);
      if (pinned) begin
         r.number_value = pinned_value;
         r.saturated = pinned_sat;
         r.run_last = 1'b1;
         expected_numbers.insert(expected_numbers.size(), r);
      end else begin
         foreach (char_numbers[i])
            expected_numbers.insert(expected_numbers.size(), char_numbers[i]);
      end
   endtask

   task automatic add_row(input logic [7:0] c, input logic eos, input bit pinned,
                          input logic signed [31:0] pinned_value, input logic pinned_sat);
      char_row_type row;
      row.char_code = c;
      row.eos = eos;
      row.pinned = pinned;
      row.pinned_value = pinned_value;
      row.pinned_sat = pinned_sat;
      directed_chars.insert(directed_chars.size(), row);
   endtask

   task automatic send_text();
      for (int i = 0; i < text_buf.size(); i++)
         drive_and_predict(text_buf[i], i == text_buf.size() - 1, 1'b0, '0, 1'b0);
   endtask

   task automatic check_number();
      sdlp_pkg::result_type want;
      results_seen++;
      if (rsp_saturated) clamped_seen++;
      if (rsp_number_value < 0) negative_seen++;
      if (expected_numbers.size() == 0) begin
         report_mismatch($sformatf("unexpected result %0d", rsp_number_value));
      end else begin
         want = expected_numbers.pop_front();
         if (rsp_number_value !== want.number_value)
            report_mismatch($sformatf("number_value %0d, expected %0d", rsp_number_value,
                                      want.number_value));
         if (rsp_saturated !== want.saturated)
            report_mismatch($sformatf("saturated %b, expected %b", rsp_saturated,
                                      want.saturated));
         if (rsp_run_last !== want.run_last)
            report_mismatch($sformatf("run_last %b, expected %b (value %0d)", rsp_run_last,
                                      want.run_last, want.number_value));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            check_number();
            rsp_wait = pick_gap(rsp_no_idle);
         end else if (rsp_wait != 0) begin
            rsp_wait--;
         end
         rsp_ready <= (rsp_wait == 0) && !hold_rsp;
      end
   end

   initial begin
      wait (stress_started);
      @(posedge clock);
      hold_rsp <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_rsp <= 1'b0;
   end

   initial begin
      int unsigned kind;
      int unsigned tokens;
      int unsigned count;
      int unsigned val;
      string       digits;

      add_row("[", 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_ZERO, 1'b1, 1'b1, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b1, 1'b1, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b0, 1'b1, 0, 1'b0);
      add_row("5", 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b0, 1'b1, -5, 1'b0);
      add_row("3", 1'b1, 1'b1, -3, 1'b0);
      for (int i = 0; i < 10; i++) add_row(sdlp_pkg::CHAR_NINE, 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_NINE, 1'b1, 1'b1, 32'sh7FFF_FFFF, 1'b1);
      add_row(8'hFF, 1'b1, 1'b0, 0, 1'b0);
      add_row("7", 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b0, 1'b1, 7, 1'b0);
      add_row("2", 1'b0, 1'b0, 0, 1'b0);
      add_row(sdlp_pkg::CHAR_MINUS, 1'b1, 1'b0, 0, 1'b0);

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_chars[i])
         drive_and_predict(directed_chars[i].char_code, directed_chars[i].eos,
                           directed_chars[i].pinned, directed_chars[i].pinned_value,
                           directed_chars[i].pinned_sat);

      stress_started = 1'b1;
      while (items_sent < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 9);
         if (kind == 0) begin
            count = $urandom_range(1, 12);
            for (int j = 0; j < count; j++)
               drive_and_predict(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
                                 1'b0, '0, 1'b0);
         end else begin
            text_buf.delete();
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), "[");
            tokens = $urandom_range(1, 6);
            for (int t = 0; t < tokens; t++) begin
               if (t != 0) begin
                  case ($urandom_range(0, 4))
                     0: text_buf.insert(text_buf.size(), ",");
                     1: text_buf.insert(text_buf.size(), " ");
                     2: begin
                        text_buf.insert(text_buf.size(), ",");
                        text_buf.insert(text_buf.size(), " ");
                     end
                     3: ;
                     default: text_buf.insert(text_buf.size(), 8'($urandom_range(0, 255)));
                  endcase
               end
               if ($urandom_range(0, 9) == 0) begin
                  text_buf.insert(text_buf.size(), sdlp_pkg::CHAR_MINUS);
               end else begin
                  if ($urandom_range(0, 1) == 1)
                     text_buf.insert(text_buf.size(), sdlp_pkg::CHAR_MINUS);
                  case ($urandom_range(0, 9))
                     0, 1, 2, 3, 4: val = $urandom_range(0, 999);
                     5, 6: val = $urandom;
                     7: begin
                        case ($urandom_range(0, 3))
                           0: val = 32'd2147483647;
                           1: val = 32'd2147483648;
                           2: val = 32'd2147483646;
                           default: val = 32'hFFFF_FFFF;
                        endcase
                     end
                     8: begin
                        count = $urandom_range(10, 14);
                        for (int j = 0; j < count; j++)
                           text_buf.insert(text_buf.size(), sdlp_pkg::CHAR_NINE);
                        val = 9;
                     end
                     default: begin
                        count = $urandom_range(1, 3);
                        for (int j = 0; j < count; j++)
                           text_buf.insert(text_buf.size(), sdlp_pkg::CHAR_ZERO);
                        val = $urandom_range(0, 99);
                     end
                  endcase
                  digits = $sformatf("%0d", val);
                  for (int j = 0; j < digits.len(); j++)
                     text_buf.insert(text_buf.size(), digits[j]);
               end
            end
            if ($urandom_range(0, 3) == 0) text_buf.insert(text_buf.size(), "]");
            send_text();
         end
      end
      req_valid <= 1'b0;

      count = 0;
      while (expected_numbers.size() != 0 && count < 5000) begin
         @(posedge clock);
         count++;
      end
      repeat (20) @(posedge clock);
      if (expected_numbers.size() != 0)
         report_mismatch($sformatf("%0d expected results never arrived",
                                   expected_numbers.size()));

      $display("Run covered %0d characters and %0d returned numbers", items_sent,
               results_seen);
      $display("  of which %0d negative and %0d clamped; %0d mismatches", negative_seen,
               clamped_seen, error_count);
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

/* filelist.f */
rtl/sdlp_pkg.sv
rtl/sdlp_step.sv
rtl/sdlp_rsp_fifo.sv
rtl/signed_decimal_list_parser_core.sv
tb/sv/tb_signed_decimal_list_parser_core.sv
